/* src/i2cmts_pkg.sv */
`default_nettype none

package i2cmts_pkg;

	// Bus commands issued to the two-wire controller.
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_GO     = 3'd3,
		CMD_GO_ACK = 3'd4
	} cmd_t;

	// Item kinds.
	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// Transfer modes.
	localparam logic [1:0] MODE_WR    = 2'd0;
	localparam logic [1:0] MODE_RD    = 2'd1;
	localparam logic [1:0] MODE_WR_RD = 2'd2;
	localparam logic [1:0] MODE_BAD   = 2'd3;

	// Bus status codes, already shifted right by three.
	localparam logic [4:0] ST_START        = 5'd1;
	localparam logic [4:0] ST_REP_START    = 5'd2;
	localparam logic [4:0] ST_SLAW_ACK     = 5'd3;
	localparam logic [4:0] ST_DATA_TX_ACK  = 5'd5;
	localparam logic [4:0] ST_SLAR_ACK     = 5'd8;
	localparam logic [4:0] ST_DATA_RX_ACK  = 5'd10;
	localparam logic [4:0] ST_DATA_RX_NACK = 5'd11;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  bus_byte;
		logic        bus_byte_valid;
		logic        tx_taken;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic        finished;
		logic        error_stop;
		logic [16:0] remaining;
	} result_t;

endpackage

`default_nettype wire

/* src/i2c_master_transaction_sequencer_unit.sv */
// Each accepted item is decoded against the sequencer state and registered into
// the result register, or into the one skid entry when that register is full and
// not being drained. Throughput: one item per cycle while the skid entry is free.
// in_ready drops only while the skid entry is occupied.
// Reset (arst_n low, asynchronous): sequencer idle, counters and mode cleared,
// no result pending.
`default_nettype none

module i2c_master_transaction_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [6:0]  slave_address,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] tx_length,
	input  wire logic [15:0] rx_length,
	input  wire logic [4:0]  bus_status,
	input  wire logic [7:0]  bus_rx_byte,
	input  wire logic [7:0]  next_tx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       command,
	output logic [7:0]       bus_byte,
	output logic             bus_byte_valid,
	output logic             tx_taken,
	output logic             rx_valid,
	output logic [7:0]       rx_byte,
	output logic             finished,
	output logic             error_stop,
	output logic [16:0]      remaining
);

	logic        idle_q;
	logic [1:0]  mode_q;
	logic [6:0]  addr_q;
	logic [15:0] tx_rem_q;
	logic [15:0] rx_rem_q;

	logic        idle_d;
	logic [1:0]  mode_d;
	logic [6:0]  addr_d;
	logic [15:0] tx_rem_d;
	logic [15:0] rx_rem_d;

	i2cmts_pkg::result_t res_d;
	i2cmts_pkg::result_t out_q;
	i2cmts_pkg::result_t skid_q;
	logic                out_v_q;
	logic                skid_v_q;

	logic accept;
	logic fin;
	logic err;
	logic tx_path;
	logic rx_path;

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		res_d    = '0;
		idle_d   = idle_q;
		mode_d   = mode_q;
		addr_d   = addr_q;
		tx_rem_d = tx_rem_q;
		rx_rem_d = rx_rem_q;
		fin      = 1'b0;
		err      = 1'b0;
		tx_path  = 1'b0;
		rx_path  = 1'b0;

		if (op == i2cmts_pkg::OP_BEGIN) begin
			// A begin is honored only when idle and with a defined mode.
			if (idle_q && mode != i2cmts_pkg::MODE_BAD) begin
				idle_d        = 1'b0;
				mode_d        = mode;
				addr_d        = slave_address;
				tx_rem_d      = (mode == i2cmts_pkg::MODE_RD) ? 16'd0 : tx_length;
				rx_rem_d      = (mode == i2cmts_pkg::MODE_WR) ? 16'd0 : rx_length;
				res_d.command = i2cmts_pkg::CMD_START;
			end
		end else if (!idle_q) begin
			unique case (bus_status)
				i2cmts_pkg::ST_START: begin
					res_d.command        = i2cmts_pkg::CMD_GO;
					res_d.bus_byte       = {addr_q, mode_q == i2cmts_pkg::MODE_RD};
					res_d.bus_byte_valid = 1'b1;
				end
				i2cmts_pkg::ST_REP_START: begin
					res_d.command        = i2cmts_pkg::CMD_GO;
					res_d.bus_byte       = {addr_q, mode_q != i2cmts_pkg::MODE_WR};
					res_d.bus_byte_valid = 1'b1;
				end
				i2cmts_pkg::ST_SLAW_ACK: begin
					tx_path = 1'b1;
				end
				i2cmts_pkg::ST_DATA_TX_ACK: begin
					if (tx_rem_q != 16'd0) begin
						tx_rem_d = tx_rem_q - 16'd1;
					end
					tx_path = 1'b1;
				end
				i2cmts_pkg::ST_SLAR_ACK: begin
					rx_path = 1'b1;
				end
				i2cmts_pkg::ST_DATA_RX_ACK: begin
					res_d.rx_valid = 1'b1;
					res_d.rx_byte  = bus_rx_byte;
					if (rx_rem_q != 16'd0) begin
						rx_rem_d = rx_rem_q - 16'd1;
					end
					rx_path = 1'b1;
				end
				i2cmts_pkg::ST_DATA_RX_NACK: begin
					res_d.rx_valid = 1'b1;
					res_d.rx_byte  = bus_rx_byte;
					if (rx_rem_q != 16'd0) begin
						rx_rem_d = rx_rem_q - 16'd1;
					end
					fin = 1'b1;
				end
				default: begin
					fin = 1'b1;
					err = 1'b1;
				end
			endcase

			if (tx_path) begin
				priority if (tx_rem_d != 16'd0) begin
					res_d.command        = i2cmts_pkg::CMD_GO;
					res_d.bus_byte       = next_tx_byte;
					res_d.bus_byte_valid = 1'b1;
					res_d.tx_taken       = 1'b1;
				end else if (mode_q == i2cmts_pkg::MODE_WR_RD) begin
					res_d.command = i2cmts_pkg::CMD_START;
				end else begin
					fin = 1'b1;
				end
			end

			if (rx_path) begin
				priority if (rx_rem_d > 16'd1) begin
					res_d.command = i2cmts_pkg::CMD_GO_ACK;
				end else if (rx_rem_d == 16'd1) begin
					res_d.command = i2cmts_pkg::CMD_GO;
				end else begin
					fin = 1'b1;
				end
			end

			if (fin) begin
				idle_d           = 1'b1;
				res_d.command    = i2cmts_pkg::CMD_STOP;
				res_d.finished   = 1'b1;
				res_d.error_stop = err;
				if (mode_q == i2cmts_pkg::MODE_WR) begin
					res_d.remaining = {1'b0, tx_rem_d};
				end else if (mode_q == i2cmts_pkg::MODE_RD) begin
					res_d.remaining = {1'b0, rx_rem_d};
				end else begin
					res_d.remaining = {1'b0, tx_rem_d} + {1'b0, rx_rem_d};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q   <= 1'b1;
			mode_q   <= 2'd0;
			addr_q   <= 7'd0;
			tx_rem_q <= 16'd0;
			rx_rem_q <= 16'd0;
		end else if (accept) begin
			idle_q   <= idle_d;
			mode_q   <= mode_d;
			addr_q   <= addr_d;
			tx_rem_q <= tx_rem_d;
			rx_rem_q <= rx_rem_d;
		end
	end

	// Result register with one skid entry; a new transfer lands in the skid
	// only when the result register is full and not being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!out_v_q || out_ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (out_ready && out_v_q) begin
				out_v_q  <= skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_v_q || out_ready) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end else if (out_ready && out_v_q && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid      = out_v_q;
	assign command        = 3'(out_q.command);
	assign bus_byte       = out_q.bus_byte;
	assign bus_byte_valid = out_q.bus_byte_valid;
	assign tx_taken       = out_q.tx_taken;
	assign rx_valid       = out_q.rx_valid;
	assign rx_byte        = out_q.rx_byte;
	assign finished       = out_q.finished;
	assign error_stop     = out_q.error_stop;
	assign remaining      = out_q.remaining;

endmodule

`default_nettype wire

/* src/i2cmts_checker.sv */
`default_nettype none

module i2cmts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  command,
	input wire logic [7:0]  bus_byte,
	input wire logic        bus_byte_valid,
	input wire logic        rx_valid,
	input wire logic [7:0]  rx_byte,
	input wire logic        finished,
	input wire logic        error_stop,
	input wire logic [16:0] remaining
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(remaining)
			&& $stable(bus_byte) && $stable(rx_byte))
		else $error("result changed while stalled");

	// Every finished transfer carries a STOP command.
	a_fin_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> command == 3'(i2cmts_pkg::CMD_STOP))
		else $error("finished without stop command");

	// Count and error flag are only reported with a stop.
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> remaining == 17'd0 && !error_stop)
		else $error("remaining or error reported without stop");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_valid |-> rx_byte == 8'd0)
		else $error("rx byte nonzero without rx_valid");

	a_bus_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_byte_valid |-> command == 3'(i2cmts_pkg::CMD_GO))
		else $error("bus byte written without proceed command");

endmodule

bind i2c_master_transaction_sequencer_unit i2cmts_checker u_i2cmts_checker (.*);

`default_nettype wire
